// ===== hw/rtl/cdq_pkg.sv =====
// cdq_pkg: shared types, widths and codes for the circular deque
// no dependencies; imported by cdq_ctrl, cdq_dp and circular_deque
package cdq_pkg;

	// default number of store entries
	localparam int DEPTH_DEFAULT = 16;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int TIME_W = 16;
	localparam int TAG_W  = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;
	localparam int WORD_W = TIME_W + TAG_W;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the input beat
		logic exec;   // update pointers and access the store
		logic fill;   // load the output register
	} cdq_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;   // output register can take a new result this cycle
	} cdq_sts_t;

endpackage

// ===== hw/rtl/circular_deque.sv =====
// circular_deque: top level of the bounded double-ended queue
// depends on cdq_pkg, cdq_ctrl and cdq_dp

// A bounded double-ended queue of DEPTH entries of time stamp and tag, kept
// in a circular store. Each input beat carries one command (push front, push
// rear, pop front, pop rear) and yields exactly one output beat with status,
// the popped entry when there is one, and the occupancy after the command.
// A push into a full deque is dropped with status full; a pop from an empty
// one changes nothing and reports status empty. The beat is captured when it
// is accepted, the store access with its registered read follows in the
// execute step, and the output register loads in the fill step. The input
// stall drops with the output load, so a new beat is accepted only once the
// previous result has been loaded into the output register. While a waiting
// result is stalled at the output, the sequencer holds in its fill step and
// the next beat waits as long as the stall lasts. The output register holds a
// waiting result while the next command is taken in. No clearing pass is
// needed after reset.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cdq_pkg::CMD_W-1:0]   cmd,
	input  logic [cdq_pkg::TIME_W-1:0]  entry_time,
	input  logic [cdq_pkg::TAG_W-1:0]   entry_tag,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cdq_pkg::STAT_W-1:0]  status,
	output logic                        data_valid,
	output logic [cdq_pkg::TIME_W-1:0]  out_time,
	output logic [cdq_pkg::TAG_W-1:0]   out_tag,
	output logic [cdq_pkg::OCC_W-1:0]   occupancy
);
	import cdq_pkg::*;

	cdq_ctl_t ctl;
	cdq_sts_t sts;

	// sequencer
	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	// pointers, store and output register
	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.entry_time (entry_time),
		.entry_tag  (entry_tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_valid (data_valid),
		.out_time   (out_time),
		.out_tag    (out_tag),
		.occupancy  (occupancy)
	);

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
// cdq_ctrl: sequencer for the circular deque (capture, execute, fill)
// depends on cdq_pkg for the command and status structs
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output cdq_pkg::cdq_ctl_t ctl,
	input  cdq_pkg::cdq_sts_t sts
);
	import cdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FILL
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign accept   = in_valid && !in_stall_q;
	assign in_stall = in_stall_q;

	// commands to the datapath
	always_comb begin
		ctl.load = accept;
		ctl.exec = (state_q == S_EXEC);
		ctl.fill = (state_q == S_FILL) && sts.out_free;
	end

	// state and registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_EXEC;
						in_stall_q <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (sts.out_free) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/cdq_dp.sv =====
// cdq_dp: datapath of the circular deque: pointers, count, entry store, output register
// depends on cdq_pkg for widths, codes and the command and status structs
module cdq_dp #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdq_pkg::cdq_ctl_t           ctl,
	output cdq_pkg::cdq_sts_t           sts,
	input  logic [cdq_pkg::CMD_W-1:0]   cmd,
	input  logic [cdq_pkg::TIME_W-1:0]  entry_time,
	input  logic [cdq_pkg::TAG_W-1:0]   entry_tag,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cdq_pkg::STAT_W-1:0]  status,
	output logic                        data_valid,
	output logic [cdq_pkg::TIME_W-1:0]  out_time,
	output logic [cdq_pkg::TAG_W-1:0]   out_tag,
	output logic [cdq_pkg::OCC_W-1:0]   occupancy
);
	import cdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	// entry store
	logic [WORD_W-1:0] mem [DEPTH];

	// captured beat
	cmd_t              cmd_q;
	logic [WORD_W-1:0] word_q;

	// deque control state
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// execute results
	logic [WORD_W-1:0] rd_q;
	logic [STAT_W-1:0] stat_q;
	logic              dv_q;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              data_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [OCC_W-1:0]  occupancy_q;

	logic          is_push;
	logic          is_front;
	logic          full;
	logic          empty;
	logic          last;
	logic [AW-1:0] head_prev;
	logic [AW-1:0] head_next;
	logic [AW-1:0] tail_prev;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] wr_slot;
	logic [AW-1:0] rd_slot;
	logic          do_write;
	logic [OCC_W+CW-1:0] count_ext;

	// command decode and slot arithmetic
	always_comb begin
		is_push   = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_REAR);
		is_front  = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_POP_FRONT);
		full      = (count_q == FULL_CNT);
		empty     = (count_q == '0);
		last      = (count_q == CW'(1));
		head_prev = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
		head_next = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
		tail_prev = (tail_q == '0) ? LAST_SLOT : tail_q - AW'(1);
		tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
		if (empty) begin
			wr_slot = '0;
		end else if (is_front) begin
			wr_slot = head_prev;
		end else begin
			wr_slot = tail_next;
		end
		rd_slot   = is_front ? head_q : tail_q;
		do_write  = ctl.exec && is_push && !full;
		count_ext = {{OCC_W{1'b0}}, count_q};
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_slot] <= word_q;
		end
		if (ctl.exec) begin
			rd_q <= mem[rd_slot];
		end
	end

	// beat capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_t'(cmd);
			word_q <= {entry_time, entry_tag};
		end
	end

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.exec) begin
			if (is_push) begin
				if (!full) begin
					if (empty) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (is_front) begin
						head_q <= head_prev;
					end else begin
						tail_q <= tail_next;
					end
					count_q <= count_q + CW'(1);
				end
			end else if (!empty) begin
				if (last) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (is_front) begin
					head_q <= head_next;
				end else begin
					tail_q <= tail_prev;
				end
				count_q <= count_q - CW'(1);
			end
		end
	end

	// result status of the executed command
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (is_push) begin
				stat_q <= full ? STAT_FULL : STAT_DONE;
				dv_q   <= 1'b0;
			end else begin
				stat_q <= empty ? STAT_EMPTY : STAT_DONE;
				dv_q   <= !empty;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.fill) begin
			status_q     <= stat_q;
			data_valid_q <= dv_q;
			out_time_q   <= dv_q ? rd_q[WORD_W-1:TAG_W] : '0;
			out_tag_q    <= dv_q ? rd_q[TAG_W-1:0] : '0;
			occupancy_q  <= count_ext[OCC_W-1:0];
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fill) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_valid = data_valid_q;
	assign out_time   = out_time_q;
	assign out_tag    = out_tag_q;
	assign occupancy  = occupancy_q;

endmodule
